>>> sv/rhws_pkg.sv
// rhws_pkg: shared widths and sequencer state type for the radix half weight split block
// no dependencies; imported by every module of the block except the ram
`timescale 1ns / 1ps

package rhws_pkg;

  localparam int VALUE_W = 64;
  localparam int RADIX_W = 16;
  localparam int DIGIT_W = 16;

  // smallest digit base the block works with
  localparam logic [RADIX_W-1:0] RADIX_MIN = 16'd2;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DIV_GO   = 8'b0000_0010,
    S_DIV_WAIT = 8'b0000_0100,
    S_SCAN     = 8'b0000_1000,
    S_RD       = 8'b0001_0000,
    S_MAC_GO   = 8'b0010_0000,
    S_MAC_WAIT = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  // handshake between the sequencer and a multi-cycle unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

>>> sv/rhws_ram.sv
// rhws_ram: generic single write port, single read port ram with registered read
// no package dependencies
`timescale 1ns / 1ps

module rhws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/rhws_divider.sv
// rhws_divider: restoring divider, 64-bit dividend by 16-bit divisor, one quotient bit per cycle
// depends on rhws_pkg
`timescale 1ns / 1ps

module rhws_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [rhws_pkg::VALUE_W-1:0] dividend,
  input  logic [rhws_pkg::RADIX_W-1:0] divisor,
  output logic [rhws_pkg::VALUE_W-1:0] quotient,
  output logic [rhws_pkg::DIGIT_W-1:0] remainder,
  output rhws_pkg::unit_stat_t         stat
);

  import rhws_pkg::*;

  localparam int CNT_W = $clog2(VALUE_W);

  logic [VALUE_W-1:0] quo;
  logic [DIGIT_W-1:0] rem;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic               done;
  logic [DIGIT_W:0]   trial;
  logic [DIGIT_W:0]   diff;
  logic               ge;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial = {rem, quo[VALUE_W-1]};
    diff  = trial - {1'b0, divisor};
    ge    = (trial >= {1'b0, divisor});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(VALUE_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[VALUE_W-2:0], ge};
      rem <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat      = '{busy: busy, done: done};

endmodule

>>> sv/rhws_horner.sv
// rhws_horner: accumulator that folds in one digit per run, acc = acc * radix + digit,
// as a shift-add over the radix bits, one bit per cycle; depends on rhws_pkg
`timescale 1ns / 1ps

module rhws_horner (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         clear,
  input  logic                         start,
  input  logic [rhws_pkg::DIGIT_W-1:0] digit,
  input  logic [rhws_pkg::RADIX_W-1:0] radix,
  output logic [rhws_pkg::VALUE_W-1:0] acc,
  output rhws_pkg::unit_stat_t         stat
);

  import rhws_pkg::*;

  localparam int BIT_W = $clog2(RADIX_W);

  logic [VALUE_W-1:0] tmp;
  logic [VALUE_W-1:0] sum;
  logic [DIGIT_W-1:0] dig;
  logic [BIT_W-1:0]   bitcnt;
  logic               busy;
  logic               done;

  // one shift-add step, digit added on the last radix bit
  always_comb begin
    sum = {tmp[VALUE_W-2:0], 1'b0}
        + (radix[bitcnt] ? acc : '0)
        + ((bitcnt == '0) ? VALUE_W'(dig) : '0);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done   <= 1'b0;
      bitcnt <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy   <= 1'b1;
        bitcnt <= BIT_W'(RADIX_W - 1);
      end else if (busy) begin
        if (bitcnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          bitcnt <= bitcnt - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (clear) begin
      acc <= '0;
    end else if (start && !busy) begin
      tmp <= '0;
      dig <= digit;
    end else if (busy) begin
      tmp <= sum;
      if (bitcnt == '0) begin
        acc <= sum;
      end
    end
  end

  assign stat = '{busy: busy, done: done};

endmodule

>>> sv/radix_half_weight_split.sv
// radix_half_weight_split: each item runs the 64-step shared divider once per extracted
// digit, then a stop search over the digits, then the 16-step shift-add fold once per
// digit from the stop position down to digit zero; a zero value goes straight to the output
// One item at a time: s_tready returns the cycle after the result is loaded, so a new item
// is taken only once the last result has gone into the output register
// Synchronous active-high reset clears control and sets the radix to 2; no ram clearing
`timescale 1ns / 1ps

module radix_half_weight_split #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  // input item
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [rhws_pkg::VALUE_W-1:0] s_tdata,   // [63:0] value
  // result item
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [rhws_pkg::VALUE_W-1:0] m_tdata,   // [63:0] low_part
  // radix register
  input  logic                         cfg_we,
  input  logic [rhws_pkg::RADIX_W-1:0] cfg_wdata
);

  import rhws_pkg::*;

  localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(MAX_DIGITS + 1);

  state_t             state;
  logic [RADIX_W-1:0] radix;
  logic [RADIX_W-1:0] radix_eff;
  logic [VALUE_W-1:0] rest;
  logic [CW-1:0]      n;
  logic [CW-1:0]      weight;
  logic [CW-1:0]      seen;
  logic [CW-1:0]      seen_next;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      k;
  logic [MAX_DIGITS-1:0] nz;

  logic               div_start;
  logic [VALUE_W-1:0] div_quo;
  logic [DIGIT_W-1:0] div_rem;
  unit_stat_t         div_stat;

  logic               mac_clear;
  logic               mac_start;
  logic [VALUE_W-1:0] mac_acc;
  unit_stat_t         mac_stat;

  logic               ram_we;
  logic [DIGIT_W-1:0] ram_rdata;
  logic               accept;
  logic               out_load;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);
  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);

  // radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_MIN;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  assign radix_eff = (radix < RADIX_MIN) ? RADIX_MIN : radix;

  // unit controls
  assign div_start = (state == S_DIV_GO);
  assign mac_start = (state == S_MAC_GO);
  assign mac_clear = accept;
  assign ram_we    = (state == S_DIV_WAIT) && div_stat.done;
  assign seen_next = seen + CW'(nz[idx]);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      n      <= '0;
      weight <= '0;
      seen   <= '0;
      idx    <= '0;
      k      <= '0;
      nz     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            n      <= '0;
            weight <= '0;
            nz     <= '0;
            state  <= (s_tdata == '0) ? S_FIN : S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            nz[n[AW-1:0]] <= (div_rem != '0);
            weight        <= weight + CW'(div_rem != '0);
            n             <= n + 1'b1;
            if (div_quo == '0 || n == CW'(MAX_DIGITS - 1)) begin
              idx   <= '0;
              seen  <= '0;
              state <= S_SCAN;
            end else begin
              state <= S_DIV_GO;
            end
          end
        end
        // find the first digit where the nonzero count reaches half the total
        S_SCAN: begin
          if (seen_next >= (weight >> 1)) begin
            k     <= idx;
            state <= S_RD;
          end else begin
            seen <= seen_next;
            idx  <= idx + 1'b1;
          end
        end
        S_RD: begin
          state <= S_MAC_GO;
        end
        S_MAC_GO: begin
          state <= S_MAC_WAIT;
        end
        // fold digits from the stop position down to digit zero
        S_MAC_WAIT: begin
          if (mac_stat.done) begin
            if (k == '0) begin
              state <= S_FIN;
            end else begin
              k     <= k - 1'b1;
              state <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // remaining value feeding the divider
  always_ff @(posedge clk) begin
    if (accept) begin
      rest <= s_tdata;
    end else if (ram_we) begin
      rest <= div_quo;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= mac_acc;
    end
  end

  rhws_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (rest),
    .divisor   (radix_eff),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  rhws_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_DIGITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (n[AW-1:0]),
    .wdata (div_rem),
    .raddr (k),
    .rdata (ram_rdata)
  );

  rhws_horner u_mac (
    .clk   (clk),
    .rst   (rst),
    .clear (mac_clear),
    .start (mac_start),
    .digit (ram_rdata),
    .radix (radix_eff),
    .acc   (mac_acc),
    .stat  (mac_stat)
  );

  // an accepted item always takes the block out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("block still ready after accepting an item");

  // digit count stays within the digit store
  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CW'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  // nonzero count never exceeds digit count
  a_weight_bound: assert property (@(posedge clk) disable iff (rst)
    weight <= n)
    else $error("nonzero digit count exceeds digit count");

  // stop search ends before running past the extracted digits
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (CW'(idx) < n))
    else $error("stop search ran past the last digit");

endmodule

>>> test/tb_radix_half_weight_split.sv
// tb_radix_half_weight_split: self-checking testbench for radix_half_weight_split
// drives value items and radix writes, predicts low_part, checks every result item in order
// depends on rhws_pkg and radix_half_weight_split
`timescale 1ns / 1ps

module tb_radix_half_weight_split;
  import rhws_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int IDLE_PCT    = 32;
  localparam int ITEMS_PER_PHASE = 17;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [VALUE_W-1:0]   s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [VALUE_W-1:0]   m_tdata;
  logic                 cfg_we = 1'b0;
  logic [RADIX_W-1:0]   cfg_wdata = '0;

  // shadow of the radix register and the queue of predicted low parts
  logic [RADIX_W-1:0]   radix_setting = RADIX_MIN;
  logic [VALUE_W-1:0]   low_part_queue[$];
  logic [VALUE_W-1:0]   want_low_part;
  bit                   idle_on = 1'b1;
  int                   error_count = 0;
  int                   cycle_count = 0;

  radix_half_weight_split u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // digit split: sum the lowest digits until half the nonzero digits are covered
  function automatic logic [VALUE_W-1:0] split_low_part(logic [VALUE_W-1:0] v,
                                                        logic [RADIX_W-1:0] r);
    logic [VALUE_W-1:0] digits[64];
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] rest;
    logic [VALUE_W-1:0] place;
    logic [VALUE_W-1:0] acc;
    int                 ndig;
    int                 weight;
    int                 target;
    int                 seen;
    base   = (r < RADIX_MIN) ? VALUE_W'(RADIX_MIN) : VALUE_W'(r);
    rest   = v;
    ndig   = 0;
    weight = 0;
    while (rest != 0 && ndig < 64) begin
      digits[ndig] = rest % base;
      rest = rest / base;
      if (digits[ndig] != 0) weight++;
      ndig++;
    end
    target = weight / 2;
    seen   = 0;
    place  = 1;
    acc    = 0;
    for (int i = 0; i < ndig; i++) begin
      if (digits[i] != 0) begin
        seen++;
        acc += digits[i] * place;
      end
      if (seen >= target) break;
      place *= base;
    end
    return acc;
  endfunction

  // random value: full width, truncated length, or a few scattered nonzero digits
  function automatic logic [VALUE_W-1:0] random_value(logic [RADIX_W-1:0] r);
    logic [VALUE_W-1:0] base;
    logic [VALUE_W-1:0] place;
    logic [VALUE_W-1:0] v;
    int                 mode;
    base = (r < RADIX_MIN) ? VALUE_W'(RADIX_MIN) : VALUE_W'(r);
    mode = $urandom_range(0, 9);
    v    = {$urandom, $urandom};
    if (mode >= 3 && mode <= 6) begin
      v = v >> $urandom_range(0, 63);
    end else if (mode >= 7) begin
      v     = 0;
      place = 1;
      // keep base * place in range so the sum never wraps
      while (1) begin
        if ($urandom_range(0, 5) == 0)
          v += VALUE_W'($urandom_range(1, int'(base) - 1)) * place;
        if (place > {VALUE_W{1'b1}} / base) break;
        place *= base;
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    error_count++;
  endtask

  // one value item, with random idle cycles before it; valid stays high afterwards
  task automatic send_value(input logic [VALUE_W-1:0] v);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = v;
    do @(posedge clk); while (!s_tready);
    low_part_queue = {low_part_queue, split_low_part(v, radix_setting)};
  endtask

  // stop sending and wait for every predicted result
  task automatic drain_results();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (low_part_queue.size() != 0) @(posedge clk);
  endtask

  // radix write while the block is idle
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    drain_results();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = r;
    @(negedge clk);
    cfg_we    = 1'b0;
    radix_setting = r;
  endtask

  // base two: extremes of the value field
  task automatic test_base_two();
    write_radix(16'd2);
    send_value(64'd0);
    send_value(64'd1);
    send_value(64'd2);
    send_value(64'd3);
    send_value({VALUE_W{1'b1}});
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h5555_5555_5555_5555);
    send_value(64'h8000_0000_0000_0001);
  endtask

  // radix of zero or one falls back to two
  task automatic test_radix_below_two();
    write_radix(16'd0);
    send_value(64'd6);
    send_value({VALUE_W{1'b1}});
    write_radix(16'd1);
    send_value(64'h0000_0000_0000_00f0);
  endtask

  // largest radix around its digit boundaries
  task automatic test_wide_radix();
    write_radix(16'hffff);
    send_value(64'd65534);
    send_value(64'd65535);
    send_value(64'd65536);
    send_value({VALUE_W{1'b1}});
    send_value(64'd65535 * 64'd65535 + 64'd1);
  endtask

  // one or two nonzero digits: the walk stops at digit zero
  task automatic test_target_zero();
    write_radix(16'd10);
    send_value(64'd7);
    send_value(64'd5000);
    send_value(64'd10_000_000_000_000_000_000);
    send_value(64'd12);
    send_value(64'd105);
    send_value(64'd1_000_000_000_000_000_001);
  endtask

  // random values over a spread of radix settings
  task automatic test_random_radices();
    logic [RADIX_W-1:0] radix_list[6];
    radix_list = '{16'd3, 16'd10, 16'd256, 16'hffff,
                   RADIX_W'($urandom_range(2, 65535)), RADIX_W'($urandom_range(2, 300))};
    for (int p = 0; p < 6; p++) begin
      write_radix(radix_list[p]);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // hold off mid-phase until the block has caught up
        if (p == 1 && i == ITEMS_PER_PHASE / 2) drain_results();
        send_value(random_value(radix_setting));
      end
    end
  endtask

  // back-to-back items with the result side always ready
  task automatic test_no_idle();
    write_radix(16'd7);
    idle_on = 1'b0;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) send_value(random_value(radix_setting));
    drain_results();
    idle_on = 1'b1;
  endtask

  // result side stalls at random, except while idle cycles are off
  always @(negedge clk) begin
    m_tready <= !idle_on || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // compare each result item with the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (low_part_queue.size() == 0) begin
        report_mismatch("unexpected low_part", m_tdata, '0);
      end else begin
        want_low_part = low_part_queue.pop_front();
        if (m_tdata !== want_low_part) report_mismatch("low_part", m_tdata, want_low_part);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_base_two();
    test_radix_below_two();
    test_wide_radix();
    test_target_zero();
    test_random_radices();
    test_no_idle();
    drain_results();
    // catch any stray result item
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
